// ===== sv/uartrx_pkg.sv =====
`default_nettype none

package uartrx_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned FILL_W    = 8;

  localparam logic [DATA_W-1:0] CH_NEXT_LO = 8'h6E;
  localparam logic [DATA_W-1:0] CH_NEXT_UP = 8'h4E;
  localparam logic [DATA_W-1:0] CH_PREV_LO = 8'h70;
  localparam logic [DATA_W-1:0] CH_PREV_UP = 8'h50;
  localparam logic [DATA_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [DATA_W-1:0] CH_EQUAL   = 8'h3D;
  localparam logic [DATA_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [DATA_W-1:0] CH_UNDER   = 8'h5F;

  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CODE_NONE = 3'd0,
    CODE_NEXT = 3'd1,
    CODE_PREV = 3'd2,
    CODE_UP   = 3'd3,
    CODE_DOWN = 3'd4
  } code_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] rx_byte;
    logic              framing_error;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic              dropped;
    logic [FILL_W-1:0] fill_count;
    code_e             command_code;
  } out_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [FILL_W-1:0] fill_next;
  } fifo_stat_t;

  function automatic code_e code_for(input logic [DATA_W-1:0] ch);
    code_e code;
    case (ch)
      CH_NEXT_LO, CH_NEXT_UP: code = CODE_NEXT;
      CH_PREV_LO, CH_PREV_UP: code = CODE_PREV;
      CH_PLUS, CH_EQUAL:      code = CODE_UP;
      CH_MINUS, CH_UNDER:     code = CODE_DOWN;
      default:                code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/uartrx_fifo.sv =====
`default_nettype none

module uartrx_fifo
  import uartrx_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              pop_i,
  output      logic [DATA_W-1:0] rdata_o,
  output      fifo_stat_t        stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [PTR_W-1:0]  wp_inc, rp_inc;
  logic              full, empty, push_ok, pop_ok;
  logic [PTR_W:0]    diff;

  assign wp_inc  = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc  = (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full    = (wp_inc == rp_q);
  assign empty   = (wp_q == rp_q);
  assign push_ok = push_i & ~full;
  assign pop_ok  = pop_i & ~empty;
  assign wp_d    = push_ok ? wp_inc : wp_q;
  assign rp_d    = pop_ok ? rp_inc : rp_q;

  // occupancy after this beat, wrapped at depth
  always_comb begin
    if (wp_d >= rp_d) begin
      diff = {1'b0, wp_d} - {1'b0, rp_d};
    end else begin
      diff = {1'b0, wp_d} + (PTR_W+1)'(DEPTH) - {1'b0, rp_d};
    end
  end

  assign stat_o.full      = full;
  assign stat_o.empty     = empty;
  assign stat_o.fill_next = FILL_W'(diff);
  assign rdata_o          = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wp_q] <= wdata_i;
    end
    if (pop_ok) begin
      rdata_q <= mem_q[rp_q];
    end
  end

endmodule

`default_nettype wire

// ===== sv/uart_rx_ring_buffer_cmd_latch.sv =====
// Receive-side byte queue with a command character latch.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
// beat: receive a byte, read one byte, or clear the latched command.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
// result beat per input beat, in order.
// Received bytes without a framing error go into a ring of DEPTH entries that
// holds DEPTH-1 bytes; a byte arriving when full is lost and flagged dropped.
// Command characters n/N, p/P, +/=, -/_ latch next, previous, up, down.
// The result is registered and appears in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the output is not stalled; the pointer update and the registered store
// read both complete in the accepting cycle.
// When the output is stalled with a result waiting, the input is stalled too
// and the waiting result holds.
// Reset empties the queue and clears the latch; store contents are left as is.

`default_nettype none

module uart_rx_ring_buffer_cmd_latch
  import uartrx_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  input  wire in_t  in_data_i,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      out_t out_data_o
);

  logic              accept, push, pop;
  logic [DATA_W-1:0] rdata;
  fifo_stat_t        stat;
  code_e             code, latch_q, latch_d;
  logic              out_valid_q;
  out_t              out_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push       = accept && in_data_i.cmd == CMD_RX && !in_data_i.framing_error;
  assign pop        = accept && in_data_i.cmd == CMD_READ;
  assign code       = code_for(in_data_i.rx_byte);

  uartrx_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_data_i.rx_byte),
    .pop_i   (pop),
    .rdata_o (rdata),
    .stat_o  (stat)
  );

  always_comb begin
    latch_d = latch_q;
    if (push && code != CODE_NONE) begin
      latch_d = code;
    end else if (accept && in_data_i.cmd == CMD_CLEAR) begin
      latch_d = CODE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= CODE_NONE;
      out_valid_q <= 1'b0;
    end else begin
      latch_q <= latch_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result fields; popped byte comes from the store read register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.read_data    <= '0;
      out_q.read_valid   <= pop & ~stat.empty;
      out_q.dropped      <= push & stat.full;
      out_q.fill_count   <= stat.fill_next;
      out_q.command_code <= latch_d;
    end
  end

  always_comb begin
    out_data_o           = out_q;
    out_data_o.read_data = out_q.read_valid ? rdata : '0;
  end

  assign out_valid_o = out_valid_q;

  a_pop_drop_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.read_valid && out_data_o.dropped))
    else $error("read and drop in one beat");

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fill_count < FILL_W'(DEPTH)) || (DEPTH > 255))
    else $error("fill count beyond depth");

  a_clear_latch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.cmd == CMD_CLEAR) |=> (out_data_o.command_code == CODE_NONE))
    else $error("latch not cleared");

  a_read_keeps_latch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.cmd == CMD_READ) |=> (latch_q == $past(latch_q)))
    else $error("read changed latch");

endmodule

`default_nettype wire
